// ----- rtl/tst_pkg.sv -----
// ----------------------------------------------------------------------------
// tst_pkg: shared types and constants of the script tokenizer
// Result beat layout, lexer mode codes, token kind codes and character codes.
// ----------------------------------------------------------------------------
package tst_pkg;

  localparam int CP_W = 21;

  typedef logic [CP_W-1:0] cp_t;

  // One result beat
  typedef struct packed {
    cp_t        token_char;
    logic       char_valid;
    logic [2:0] token_kind;
    logic       token_first;
    logic       token_last;
    logic       run_last;
  } res_t;

  // Lexer modes
  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_IDENT = 3'd1;
  localparam logic [2:0] MODE_NUM   = 3'd2;
  localparam logic [2:0] MODE_TEXT  = 3'd3;
  localparam logic [2:0] MODE_MINUS = 3'd4;
  localparam logic [2:0] MODE_STR   = 3'd5;

  // Token kinds
  localparam logic [2:0] KIND_IDENT  = 3'd0;
  localparam logic [2:0] KIND_VALUE  = 3'd1;
  localparam logic [2:0] KIND_TEXT   = 3'd2;
  localparam logic [2:0] KIND_LBRACK = 3'd3;
  localparam logic [2:0] KIND_RBRACK = 3'd4;
  localparam logic [2:0] KIND_ASSIGN = 3'd5;

  // Characters with a meaning of their own
  localparam cp_t CH_SEMI   = 21'h00003B;
  localparam cp_t CH_UNDER  = 21'h00005F;
  localparam cp_t CH_DOT    = 21'h00002E;
  localparam cp_t CH_MINUS  = 21'h00002D;
  localparam cp_t CH_LBRACK = 21'h00005B;
  localparam cp_t CH_RBRACK = 21'h00005D;
  localparam cp_t CH_EQ     = 21'h00003D;
  localparam cp_t CH_QUOTE  = 21'h000022;
  localparam cp_t CH_BSLASH = 21'h00005C;

  localparam int MAX_RES = 3;

endpackage

// ----- rtl/tst_if.sv -----
// ----------------------------------------------------------------------------
// tst_if: input and result channels of the script tokenizer
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tst_in_if;
  logic         valid;
  logic         ready;
  tst_pkg::cp_t code_point;
  logic         line_end;

  modport source (output valid, output code_point, output line_end, input ready);
  modport sink   (input valid, input code_point, input line_end, output ready);
endinterface

interface tst_out_if;
  logic         valid;
  logic         ready;
  tst_pkg::cp_t token_char;
  logic         char_valid;
  logic [2:0]   token_kind;
  logic         token_first;
  logic         token_last;
  logic         run_last;

  modport source (output valid, output token_char, output char_valid,
                  output token_kind, output token_first, output token_last,
                  output run_last, input ready);
  modport sink   (input valid, input token_char, input char_valid,
                  input token_kind, input token_first, input token_last,
                  input run_last, output ready);
endinterface

// ----- rtl/tst_lexer.sv -----
// ----------------------------------------------------------------------------
// tst_lexer: lexer state and one-character step logic
// Holds the running line state and turns one character into up to three
// result beats in a single pass of combinational logic.
// ----------------------------------------------------------------------------
module tst_lexer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  tst_pkg::cp_t        code_point,
  input  logic                line_end,
  output tst_pkg::res_t [2:0] res,
  output logic [1:0]          res_cnt
);

  typedef struct packed {
    logic [2:0]          mode;
    logic                in_tag;
    tst_pkg::cp_t        h0;
    tst_pkg::cp_t        h1;
    logic [1:0]          hcnt;
    logic                dot;
    logic                bs;
    logic                ls;
    logic                cl;
    logic                started;
    tst_pkg::res_t [2:0] res;
    logic [1:0]          n;
  } ctx_t;

  function automatic logic is_space(tst_pkg::cp_t c);
    return (c >= 21'h09 && c <= 21'h0D) || c == 21'h20 || c == 21'h85 ||
           c == 21'hA0 || c == 21'h1680 || (c >= 21'h2000 && c <= 21'h200A) ||
           c == 21'h2028 || c == 21'h2029 || c == 21'h202F || c == 21'h205F ||
           c == 21'h3000;
  endfunction

  function automatic logic is_digit(tst_pkg::cp_t c);
    return c >= 21'h30 && c <= 21'h39;
  endfunction

  function automatic logic is_alpha(tst_pkg::cp_t c);
    return (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A);
  endfunction

  function automatic logic [2:0] free_kind(ctx_t c);
    return c.in_tag ? tst_pkg::KIND_VALUE : tst_pkg::KIND_TEXT;
  endfunction

  function automatic ctx_t emit(ctx_t c, tst_pkg::cp_t ch, logic v, logic [2:0] k,
                                logic last);
    tst_pkg::res_t r;
    r.token_char  = ch;
    r.char_valid  = v;
    r.token_kind  = k;
    r.token_first = !c.started;
    r.token_last  = last;
    r.run_last    = 1'b0;
    if (c.n != 2'(tst_pkg::MAX_RES)) begin
      c.res[c.n] = r;
      c.n        = c.n + 2'd1;
      c.started  = !last;
    end
    return c;
  endfunction

  function automatic ctx_t hold(ctx_t c, tst_pkg::cp_t x);
    c.h0   = x;
    c.hcnt = 2'd1;
    return c;
  endfunction

  function automatic ctx_t start_token(ctx_t c, tst_pkg::cp_t x);
    c.mode    = tst_pkg::MODE_IDLE;
    c.hcnt    = 2'd0;
    c.started = 1'b0;
    if (!is_space(x)) begin
      if (c.in_tag && is_alpha(x)) begin
        c.mode = tst_pkg::MODE_IDENT;
        c = hold(c, x);
      end else if (c.in_tag && is_digit(x)) begin
        c.mode = tst_pkg::MODE_NUM;
        c.dot  = 1'b0;
        c = hold(c, x);
      end else if (x == tst_pkg::CH_MINUS) begin
        c.mode = tst_pkg::MODE_MINUS;
        c = hold(c, x);
      end else if (x == tst_pkg::CH_QUOTE) begin
        c.mode = tst_pkg::MODE_STR;
        c.bs   = 1'b0;
      end else if (x == tst_pkg::CH_LBRACK) begin
        c = emit(c, x, 1'b1, tst_pkg::KIND_LBRACK, 1'b1);
        c.in_tag = 1'b1;
      end else if (x == tst_pkg::CH_RBRACK) begin
        c = emit(c, x, 1'b1, tst_pkg::KIND_RBRACK, 1'b1);
        c.in_tag = 1'b0;
      end else if (x == tst_pkg::CH_EQ) begin
        c = emit(c, x, 1'b1, tst_pkg::KIND_ASSIGN, 1'b1);
        c.in_tag = 1'b0;
      end else begin
        c.mode = tst_pkg::MODE_TEXT;
        c = hold(c, x);
      end
    end
    return c;
  endfunction

  function automatic ctx_t text_step(ctx_t c, tst_pkg::cp_t x);
    if (!(is_space(x) || x == tst_pkg::CH_LBRACK || x == tst_pkg::CH_RBRACK)) begin
      c = emit(c, c.h0, 1'b1, free_kind(c), 1'b0);
      c = hold(c, x);
    end else begin
      c = emit(c, c.h0, 1'b1, free_kind(c), 1'b1);
      c = start_token(c, x);
    end
    return c;
  endfunction

  function automatic ctx_t str_push(ctx_t c, tst_pkg::cp_t ch);
    if (c.hcnt != 2'd0) begin
      c = emit(c, c.h0, 1'b1, free_kind(c), 1'b0);
    end
    c = hold(c, ch);
    return c;
  endfunction

  function automatic ctx_t str_close(ctx_t c);
    if (c.hcnt != 2'd0) begin
      c = emit(c, c.h0, 1'b1, free_kind(c), 1'b1);
    end else begin
      c = emit(c, '0, 1'b0, free_kind(c), 1'b1);
    end
    return c;
  endfunction

  function automatic ctx_t str_step(ctx_t c, tst_pkg::cp_t x);
    logic done;
    done = 1'b0;
    if (c.bs) begin
      c.bs = 1'b0;
      if (x == tst_pkg::CH_QUOTE) begin
        // escaped quote: drop the backslash, keep the quote as content
        c    = str_push(c, x);
        done = 1'b1;
      end else begin
        c = str_push(c, tst_pkg::CH_BSLASH);
      end
    end
    if (!done) begin
      if (x == tst_pkg::CH_QUOTE) begin
        c         = str_close(c);
        c.mode    = tst_pkg::MODE_IDLE;
        c.hcnt    = 2'd0;
        c.started = 1'b0;
      end else if (x == tst_pkg::CH_BSLASH) begin
        c.bs = 1'b1;
      end else begin
        c = str_push(c, x);
      end
    end
    return c;
  endfunction

  function automatic ctx_t num_step(ctx_t c, tst_pkg::cp_t x);
    if (c.hcnt >= 2'd2) begin
      if (is_digit(x)) begin
        c = emit(c, c.h0, 1'b1, tst_pkg::KIND_VALUE, 1'b0);
        c = emit(c, c.h1, 1'b1, tst_pkg::KIND_VALUE, 1'b0);
        c = hold(c, x);
      end else begin
        // dot without a digit after it: number ends, dot opens a run
        c      = emit(c, c.h0, 1'b1, tst_pkg::KIND_VALUE, 1'b1);
        c.mode = tst_pkg::MODE_TEXT;
        c      = hold(c, c.h1);
        c      = text_step(c, x);
      end
    end else if (is_digit(x)) begin
      c = emit(c, c.h0, 1'b1, tst_pkg::KIND_VALUE, 1'b0);
      c = hold(c, x);
    end else if (!c.dot && x == tst_pkg::CH_DOT) begin
      c.h1   = x;
      c.hcnt = 2'd2;
      c.dot  = 1'b1;
    end else begin
      c = emit(c, c.h0, 1'b1, tst_pkg::KIND_VALUE, 1'b1);
      c = start_token(c, x);
    end
    return c;
  endfunction

  function automatic ctx_t process(ctx_t c, tst_pkg::cp_t x);
    unique case (c.mode)
      tst_pkg::MODE_IDENT: begin
        if (is_alpha(x) || is_digit(x) || x == tst_pkg::CH_UNDER) begin
          c = emit(c, c.h0, 1'b1, tst_pkg::KIND_IDENT, 1'b0);
          c = hold(c, x);
        end else begin
          c = emit(c, c.h0, 1'b1, tst_pkg::KIND_IDENT, 1'b1);
          c = start_token(c, x);
        end
      end
      tst_pkg::MODE_TEXT: c = text_step(c, x);
      tst_pkg::MODE_MINUS: begin
        if (is_digit(x)) begin
          c      = emit(c, c.h0, 1'b1, tst_pkg::KIND_VALUE, 1'b0);
          c.mode = tst_pkg::MODE_NUM;
          c.dot  = 1'b0;
          c      = hold(c, x);
        end else begin
          c.mode = tst_pkg::MODE_TEXT;
          c      = text_step(c, x);
        end
      end
      tst_pkg::MODE_NUM: c = num_step(c, x);
      tst_pkg::MODE_STR: c = str_step(c, x);
      default: c = start_token(c, x);
    endcase
    return c;
  endfunction

  function automatic ctx_t flush_line(ctx_t c);
    unique case (c.mode)
      tst_pkg::MODE_IDENT: c = emit(c, c.h0, 1'b1, tst_pkg::KIND_IDENT, 1'b1);
      tst_pkg::MODE_TEXT,
      tst_pkg::MODE_MINUS: c = emit(c, c.h0, 1'b1, free_kind(c), 1'b1);
      tst_pkg::MODE_NUM: begin
        c = emit(c, c.h0, 1'b1, tst_pkg::KIND_VALUE, 1'b1);
        if (c.hcnt >= 2'd2) begin
          c = emit(c, c.h1, 1'b1, free_kind(c), 1'b1);
        end
      end
      tst_pkg::MODE_STR: begin
        // open string at line end: keep a pending backslash as content
        if (c.bs) begin
          c = str_push(c, tst_pkg::CH_BSLASH);
        end
        c = str_close(c);
      end
      default: c = c;
    endcase
    return c;
  endfunction

  logic [2:0]   mode_r;
  logic         in_tag_r;
  tst_pkg::cp_t h0_r, h1_r;
  logic [1:0]   hcnt_r;
  logic         dot_r, bs_r, ls_r, cl_r, started_r;

  ctx_t cur, nxt;

  always_comb begin
    cur         = '0;
    cur.mode    = mode_r;
    cur.in_tag  = in_tag_r;
    cur.h0      = h0_r;
    cur.h1      = h1_r;
    cur.hcnt    = hcnt_r;
    cur.dot     = dot_r;
    cur.bs      = bs_r;
    cur.ls      = ls_r;
    cur.cl      = cl_r;
    cur.started = started_r;

    nxt = cur;
    if (nxt.ls) begin
      nxt.ls = 1'b0;
      if (code_point == tst_pkg::CH_SEMI) begin
        nxt.cl = 1'b1;
      end
    end
    if (!nxt.cl) begin
      nxt = process(nxt, code_point);
    end
    if (line_end) begin
      if (!nxt.cl) begin
        nxt = flush_line(nxt);
      end
      nxt.mode    = tst_pkg::MODE_IDLE;
      nxt.in_tag  = 1'b0;
      nxt.hcnt    = 2'd0;
      nxt.dot     = 1'b0;
      nxt.bs      = 1'b0;
      nxt.ls      = 1'b1;
      nxt.cl      = 1'b0;
      nxt.started = 1'b0;
    end
    if (nxt.n != 2'd0) begin
      nxt.res[nxt.n - 2'd1].run_last = 1'b1;
    end
  end

  assign res     = nxt.res;
  assign res_cnt = nxt.n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= tst_pkg::MODE_IDLE;
      in_tag_r  <= 1'b0;
      hcnt_r    <= 2'd0;
      dot_r     <= 1'b0;
      bs_r      <= 1'b0;
      ls_r      <= 1'b1;
      cl_r      <= 1'b0;
      started_r <= 1'b0;
    end else if (step) begin
      mode_r    <= nxt.mode;
      in_tag_r  <= nxt.in_tag;
      hcnt_r    <= nxt.hcnt;
      dot_r     <= nxt.dot;
      bs_r      <= nxt.bs;
      ls_r      <= nxt.ls;
      cl_r      <= nxt.cl;
      started_r <= nxt.started;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      h0_r <= nxt.h0;
      h1_r <= nxt.h1;
    end
  end

endmodule

// ----- rtl/tst_res_buf.sv -----
// ----------------------------------------------------------------------------
// tst_res_buf: result register bank
// Holds the up to three results of one character and sends them one beat at
// a time; frees up in the cycle its last beat leaves.
// ----------------------------------------------------------------------------
module tst_res_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  tst_pkg::res_t [2:0] res_in,
  input  logic [1:0]          cnt_in,
  output logic                free,
  tst_out_if.source           out_bus
);

  tst_pkg::res_t res_r [tst_pkg::MAX_RES];
  logic [1:0]    rem_r, rem_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic          beat;
  tst_pkg::res_t cur;

  assign beat = out_bus.valid && out_bus.ready;
  assign free = (rem_r == 2'd0) || (rem_r == 2'd1 && out_bus.ready);
  assign cur  = res_r[idx_r];

  assign out_bus.valid       = rem_r != 2'd0;
  assign out_bus.token_char  = cur.token_char;
  assign out_bus.char_valid  = cur.char_valid;
  assign out_bus.token_kind  = cur.token_kind;
  assign out_bus.token_first = cur.token_first;
  assign out_bus.token_last  = cur.token_last;
  assign out_bus.run_last    = cur.run_last;

  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (load) begin
      rem_nxt = cnt_in;
      idx_nxt = 2'd0;
    end else if (beat) begin
      rem_nxt = rem_r - 2'd1;
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < tst_pkg::MAX_RES; i++) begin
        res_r[i] <= res_in[i];
      end
    end
  end

endmodule

// ----- rtl/tagged_script_tokenizer.sv -----
// ----------------------------------------------------------------------------
// tagged_script_tokenizer: line-oriented script tokenizer
// Input register, lexer step logic and a three-entry result bank.
// ----------------------------------------------------------------------------
// One character enters per beat and is registered; once the result bank is
// free, the lexer turns it into zero to three result beats, which land in the
// result bank. A character that yields no result or one result can be taken
// every cycle while the result port is not stalled; one that yields more
// holds the result bank until its last beat leaves, so the input rate is set by
// the single result port. Comment lines, spaces between tokens and opening
// quotes produce no result beats of their own.
// ----------------------------------------------------------------------------
module tagged_script_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  tst_in_if.sink     in_bus,
  tst_out_if.source  out_bus
);

  logic                vld_r;
  tst_pkg::cp_t        cp_r;
  logic                le_r;
  logic                free;
  logic                adv;
  tst_pkg::res_t [2:0] res;
  logic [1:0]          res_cnt;

  // advance the held character into the lexer once the result bank can take it
  assign adv          = vld_r && free;
  assign in_bus.ready = !vld_r || free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      vld_r <= 1'b1;
    end else if (adv) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      cp_r <= in_bus.code_point;
      le_r <= in_bus.line_end;
    end
  end

  tst_lexer u_lexer (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .code_point (cp_r),
    .line_end   (le_r),
    .res        (res),
    .res_cnt    (res_cnt)
  );

  tst_res_buf u_res_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (adv),
    .res_in  (res),
    .cnt_in  (res_cnt),
    .free    (free),
    .out_bus (out_bus)
  );

endmodule
